// ===== rtl/qte_pkg.sv =====
// shared types, constants and tables for the quaternion to euler block
package qte_pkg;

  localparam int Q_W        = 16;
  localparam int PROD_W     = 32;
  localparam int VEC_W      = 34;
  localparam int CORDIC_W   = 36;
  localparam int S_W        = 30;
  localparam int ROOT_W     = 29;
  localparam int RAD_W      = 58;
  localparam int REM_W      = ROOT_W + 4;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int ANG_W      = 16;
  localparam int ACC_W      = 32;
  localparam int MAX_STAGES = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [VEC_W-1:0] ASIN_HI   = VEC_W'(268432772);
  localparam logic signed [VEC_W-1:0] ONE_Q28   = VEC_W'(268435456);
  localparam logic [RAD_W-1:0]        ONE_Q56   = RAD_W'(1) << 56;
  localparam logic [ACC_W-1:0]        ACC_PI    = 32'h8000_0000;
  localparam logic [ACC_W-1:0]        ACC_ROUND = 32'h0000_8000;

  typedef struct packed {
    logic signed [VEC_W-1:0] yaw_y;
    logic signed [VEC_W-1:0] yaw_x;
    logic signed [VEC_W-1:0] roll_y;
    logic signed [VEC_W-1:0] roll_x;
    logic signed [S_W-1:0]   s;
    logic                    flag;
  } side_t;

  function automatic logic [ACC_W-1:0] atan_ent(input int i);
    logic [ACC_W-1:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/qte_isqrt.sv =====
// pipelined floor square root, one result bit per stage
module qte_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [qte_pkg::RAD_W-1:0]        rad,
  output logic [qte_pkg::ROOT_W-1:0]       root
);

  logic [qte_pkg::REM_W-1:0]  rem_r  [qte_pkg::SQ_STAGES+1];
  logic [qte_pkg::ROOT_W-1:0] root_r [qte_pkg::SQ_STAGES+1];
  logic [qte_pkg::RAD_W-1:0]  rad_r  [qte_pkg::SQ_STAGES+1];

  always_comb begin
    rem_r[0]  = '0;
    root_r[0] = '0;
    rad_r[0]  = rad;
  end

  for (genvar k = 0; k < qte_pkg::SQ_STAGES; k++) begin : g_stage
    logic [qte_pkg::REM_W-1:0] cur;
    logic [qte_pkg::REM_W-1:0] trial;
    logic                      ge;
    always_comb begin
      cur   = {rem_r[k][qte_pkg::REM_W-3:0], rad_r[k][qte_pkg::RAD_W-1 -: 2]};
      trial = qte_pkg::REM_W'({root_r[k], 2'b01});
      ge    = (cur >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? (cur - trial) : cur;
        root_r[k+1] <= {root_r[k][qte_pkg::ROOT_W-2:0], ge};
        rad_r[k+1]  <= {rad_r[k][qte_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[qte_pkg::SQ_STAGES];

endmodule

// ===== rtl/qte_cordic.sv =====
// pipelined vectoring cordic giving atan2 as a binary angle
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [qte_pkg::VEC_W-1:0]  in_y,
  input  logic signed [qte_pkg::VEC_W-1:0]  in_x,
  output logic signed [qte_pkg::ANG_W-1:0]  angle
);

  localparam int N = (STAGES > qte_pkg::MAX_STAGES) ? qte_pkg::MAX_STAGES : STAGES;

  logic signed [qte_pkg::CORDIC_W-1:0] x_r   [N+1];
  logic signed [qte_pkg::CORDIC_W-1:0] y_r   [N+1];
  logic        [qte_pkg::ACC_W-1:0]    acc_r [N+1];
  logic                                zero_r[N+1];
  logic signed [qte_pkg::CORDIC_W-1:0] xe, ye;
  logic        [qte_pkg::ACC_W-1:0]    acc_out;

  always_comb begin
    xe = qte_pkg::CORDIC_W'(in_x);
    ye = qte_pkg::CORDIC_W'(in_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        x_r[0]   <= -xe;
        y_r[0]   <= -ye;
        acc_r[0] <= qte_pkg::ACC_PI;
      end else begin
        x_r[0]   <= xe;
        y_r[0]   <= ye;
        acc_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [qte_pkg::CORDIC_W-1:0] dx, dy;
    always_comb begin
      dx = x_r[i] >>> i;
      dy = y_r[i] >>> i;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][qte_pkg::CORDIC_W-1]) begin
          x_r[i+1]   <= x_r[i] + dy;
          y_r[i+1]   <= y_r[i] - dx;
          acc_r[i+1] <= acc_r[i] + qte_pkg::atan_ent(i);
        end else begin
          x_r[i+1]   <= x_r[i] - dy;
          y_r[i+1]   <= y_r[i] + dx;
          acc_r[i+1] <= acc_r[i] - qte_pkg::atan_ent(i);
        end
      end
    end
  end

  assign acc_out = acc_r[N] + qte_pkg::ACC_ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zero_r[N] ? '0 : $signed(acc_out[qte_pkg::ACC_W-1 -: qte_pkg::ANG_W]);
    end
  end

endmodule

// ===== rtl/quaternion_to_euler_zyx_top.sv =====
// top level: quaternion to zyx euler angles, fully pipelined
// Takes one quaternion per cycle while a valid output is not stalled and returns yaw, pitch
// and roll through four front-end stages for products, sums and clamp, squaring and 1 - s^2,
// a 29-stage square root for the pitch cosine term, then three parallel vectoring cordic
// pipelines with an input and an output stage. When a valid output is stalled the whole
// pipeline holds and in_stall is raised.
module quaternion_to_euler_zyx_top #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [qte_pkg::Q_W-1:0]    in_quat_w,
  input  logic signed [qte_pkg::Q_W-1:0]    in_quat_x,
  input  logic signed [qte_pkg::Q_W-1:0]    in_quat_y,
  input  logic signed [qte_pkg::Q_W-1:0]    in_quat_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qte_pkg::ANG_W-1:0]  out_yaw_angle,
  output logic signed [qte_pkg::ANG_W-1:0]  out_pitch_angle,
  output logic signed [qte_pkg::ANG_W-1:0]  out_roll_angle,
  output logic                              out_pitch_clamped
);

  localparam int N   = (CORDIC_STAGES > qte_pkg::MAX_STAGES) ? qte_pkg::MAX_STAGES
                                                             : CORDIC_STAGES;
  localparam int CL  = N + 2;
  localparam int LAT = 4 + qte_pkg::SQ_STAGES + CL;

  logic adv;
  logic vld_r [LAT];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign out_valid = vld_r[LAT-1];

  // products
  logic signed [qte_pkg::PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, wy_r, xz_r, yz_r, wx_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ww_r <= in_quat_w * in_quat_w;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      wz_r <= in_quat_w * in_quat_z;
      wy_r <= in_quat_w * in_quat_y;
      xz_r <= in_quat_x * in_quat_z;
      yz_r <= in_quat_y * in_quat_z;
      wx_r <= in_quat_w * in_quat_x;
    end
  end

  // sums and asin clamp
  logic signed [qte_pkg::VEC_W-1:0] s_raw;
  qte_pkg::side_t s2_nxt, s2_r, s3_r, s4_r;

  always_comb begin
    s2_nxt.yaw_y  = (qte_pkg::VEC_W'(xy_r) + qte_pkg::VEC_W'(wz_r)) <<< 1;
    s2_nxt.yaw_x  = qte_pkg::VEC_W'(ww_r) + qte_pkg::VEC_W'(xx_r)
                  - qte_pkg::VEC_W'(yy_r) - qte_pkg::VEC_W'(zz_r);
    s2_nxt.roll_y = (qte_pkg::VEC_W'(yz_r) + qte_pkg::VEC_W'(wx_r)) <<< 1;
    s2_nxt.roll_x = qte_pkg::VEC_W'(ww_r) - qte_pkg::VEC_W'(xx_r)
                  - qte_pkg::VEC_W'(yy_r) + qte_pkg::VEC_W'(zz_r);
    s_raw         = (qte_pkg::VEC_W'(wy_r) - qte_pkg::VEC_W'(xz_r)) <<< 1;
    if (s_raw > qte_pkg::ASIN_HI) begin
      s2_nxt.s    = qte_pkg::S_W'(qte_pkg::ASIN_HI);
      s2_nxt.flag = 1'b1;
    end else if (s_raw < -qte_pkg::ONE_Q28) begin
      s2_nxt.s    = qte_pkg::S_W'(-qte_pkg::ONE_Q28);
      s2_nxt.flag = 1'b1;
    end else begin
      s2_nxt.s    = qte_pkg::S_W'(s_raw);
      s2_nxt.flag = 1'b0;
    end
  end

  // square of s, then 1 - s^2
  logic [qte_pkg::ROOT_W-1:0] mag;
  logic [qte_pkg::RAD_W-1:0]  sq_r, rad_r;

  assign mag = s2_r.s[qte_pkg::S_W-1] ? qte_pkg::ROOT_W'(-s2_r.s)
                                       : qte_pkg::ROOT_W'(s2_r.s);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r  <= s2_nxt;
      s3_r  <= s2_r;
      sq_r  <= qte_pkg::RAD_W'(mag) * qte_pkg::RAD_W'(mag);
      s4_r  <= s3_r;
      rad_r <= qte_pkg::ONE_Q56 - sq_r;
    end
  end

  logic [qte_pkg::ROOT_W-1:0] root;

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad_r),
    .root (root)
  );

  // side data travels alongside the square root
  qte_pkg::side_t dly_r [qte_pkg::SQ_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= s4_r;
      for (int i = 1; i < qte_pkg::SQ_STAGES; i++) dly_r[i] <= dly_r[i-1];
    end
  end

  qte_pkg::side_t side;
  logic signed [qte_pkg::VEC_W-1:0] pitch_y, pitch_x;

  assign side    = dly_r[qte_pkg::SQ_STAGES-1];
  assign pitch_y = qte_pkg::VEC_W'(side.s);
  assign pitch_x = $signed(qte_pkg::VEC_W'(root));

  qte_cordic #(.STAGES(N)) u_yaw (
    .clk (clk), .en (adv), .in_y (side.yaw_y), .in_x (side.yaw_x), .angle (out_yaw_angle)
  );

  qte_cordic #(.STAGES(N)) u_pitch (
    .clk (clk), .en (adv), .in_y (pitch_y), .in_x (pitch_x), .angle (out_pitch_angle)
  );

  qte_cordic #(.STAGES(N)) u_roll (
    .clk (clk), .en (adv), .in_y (side.roll_y), .in_x (side.roll_x), .angle (out_roll_angle)
  );

  logic flag_r [CL];

  always_ff @(posedge clk) begin
    if (adv) begin
      flag_r[0] <= side.flag;
      for (int i = 1; i < CL; i++) flag_r[i] <= flag_r[i-1];
    end
  end

  assign out_pitch_clamped = flag_r[CL-1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("item dropped while output stalled");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle >= -16'sd16384) && (out_pitch_angle <= 16'sd16384))
    else $error("pitch angle outside quarter turn");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid output right after reset");

endmodule

// ===== test/qte_checker.sv =====
// item monitor, euler angle predictor and result comparator for the quaternion block
`timescale 1ns / 100ps
module qte_checker #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [qte_pkg::Q_W-1:0]   in_quat_w,
  input  logic signed [qte_pkg::Q_W-1:0]   in_quat_x,
  input  logic signed [qte_pkg::Q_W-1:0]   in_quat_y,
  input  logic signed [qte_pkg::Q_W-1:0]   in_quat_z,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [qte_pkg::ANG_W-1:0] out_yaw_angle,
  input  logic signed [qte_pkg::ANG_W-1:0] out_pitch_angle,
  input  logic signed [qte_pkg::ANG_W-1:0] out_roll_angle,
  input  logic                             out_pitch_clamped,
  output int                               errors,
  output int                               pending
);

  typedef struct {
    logic [qte_pkg::ANG_W-1:0] yaw;
    logic [qte_pkg::ANG_W-1:0] pitch;
    logic [qte_pkg::ANG_W-1:0] roll;
    logic                      clamped;
  } euler_t;

  localparam int NSTAGES = CORDIC_STAGES > qte_pkg::MAX_STAGES ? qte_pkg::MAX_STAGES
                                                              : CORDIC_STAGES;
  localparam longint S_HI = 268432772;
  localparam longint S_LO = -268435456;

  localparam bit [31:0] ARCTAN_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  euler_t angles_q[$];

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [qte_pkg::ANG_W-1:0] vector_angle(longint y, longint x);
    bit [31:0] acc;
    longint dx;
    longint dy;
    acc = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < NSTAGES; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy;
        y -= dx;
        acc += ARCTAN_STEP[i];
      end else begin
        x -= dy;
        y += dx;
        acc -= ARCTAN_STEP[i];
      end
    end
    acc += 32'h0000_8000;
    return acc[31:16];
  endfunction

  function automatic euler_t quat_to_euler(longint w, longint x, longint y, longint z);
    euler_t e;
    longint s;
    longint c;
    e.clamped = 1'b0;
    e.yaw = vector_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
    s = 2 * (w * y - x * z);
    if (s > S_HI) begin
      s = S_HI;
      e.clamped = 1'b1;
    end else if (s < S_LO) begin
      s = S_LO;
      e.clamped = 1'b1;
    end
    c = longint'(floor_sqrt(64'((longint'(1) << 56) - s * s)));
    e.pitch = vector_angle(s, c);
    e.roll = vector_angle(2 * (y * z + w * x), w * w - x * x - y * y + z * z);
    return e;
  endfunction

  always @(posedge clk) begin
    euler_t e;
    if (!rst_n) begin
      errors <= 0;
      pending <= 0;
      angles_q.delete();
    end else begin
      if (in_valid && !in_stall)
        angles_q.push_back(quat_to_euler(in_quat_w, in_quat_x, in_quat_y, in_quat_z));
      if (out_valid && !out_stall) begin
        if (angles_q.size() == 0) begin
          $display("%0t: unexpected result item yaw %0d pitch %0d roll %0d", $time,
                   out_yaw_angle, out_pitch_angle, out_roll_angle);
          errors <= errors + 1;
        end else begin
          e = angles_q.pop_front();
          if (e.yaw !== out_yaw_angle || e.pitch !== out_pitch_angle ||
              e.roll !== out_roll_angle || e.clamped !== out_pitch_clamped) begin
            $display("%0t: expected yaw %0d pitch %0d roll %0d clamp %0b, got %0d %0d %0d %0b",
                     $time, $signed(e.yaw), $signed(e.pitch), $signed(e.roll), e.clamped,
                     out_yaw_angle, out_pitch_angle, out_roll_angle, out_pitch_clamped);
            errors <= errors + 1;
          end
        end
      end
      pending <= angles_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// stimulus, flow control and verdict for the quaternion to euler block
`timescale 1ns / 100ps
module testbench;

  localparam int LIMIT = 300000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [qte_pkg::Q_W-1:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic out_valid;
  logic out_stall;
  logic signed [qte_pkg::ANG_W-1:0] out_yaw_angle, out_pitch_angle, out_roll_angle;
  logic out_pitch_clamped;
  int errors;
  int pending;
  int tx_pct;
  int rx_pct;
  int hold_cycles;
  int cycles;

  quaternion_to_euler_zyx_top uut (.*);
  qte_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1;
        hold_cycles--;
      end else begin
        out_stall = ($urandom_range(99) < rx_pct);
      end
    end
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < tx_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_quat_w = w;
    in_quat_x = x;
    in_quat_y = y;
    in_quat_z = z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int mode;
    int r;
    mode = $urandom_range(9);
    if (mode < 3) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      r = (mode < 6) ? 16384 : 11586;
      send_quat(16'($urandom_range(2 * r) - r), 16'($urandom_range(2 * r) - r),
                16'($urandom_range(2 * r) - r), 16'($urandom_range(2 * r) - r));
    end
  endtask

  initial begin
    in_valid = 0;
    in_quat_w = 0;
    in_quat_x = 0;
    in_quat_y = 0;
    in_quat_z = 0;
    hold_cycles = 0;
    tx_pct = 32;
    rx_pct = 86;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // zero vector, identity and sign flips
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    // pitch at the bounds
    send_quat(11585, 0, 11585, 0);
    send_quat(11586, 0, 11586, 0);
    send_quat(16384, 0, -8192, 0);
    send_quat(16384, 0, -8193, 0);
    send_quat(16384, 2, 8192, 671);
    send_quat(16384, 2, 8192, 670);
    // field extremes
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, 0, -32768, 0);
    send_quat(0, 32767, 0, 32767);
    send_quat(1, -1, 1, -1);
    send_quat(8192, 8192, 8192, 8192);

    for (int i = 0; i < 250; i++) send_random();

    tx_pct = 86;
    rx_pct = 32;
    for (int i = 0; i < 250; i++) send_random();

    tx_pct = 0;
    rx_pct = 0;
    hold_cycles = 300;
    for (int i = 0; i < 120; i++) send_random();
    in_valid = 0;
    wait (pending == 0);
    @(negedge clk);
    for (int i = 0; i < 130; i++) send_random();
    in_valid = 0;

    wait (pending == 0);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
